// File: src/match_geometry_residual_defines.svh
// ----------------------------------------------------------------------------
// Match geometry residual assertion macros
// Shared assertion forms for the checker of the residual block.
// ----------------------------------------------------------------------------
`ifndef MATCH_GEOMETRY_RESIDUAL_DEFINES_SVH
`define MATCH_GEOMETRY_RESIDUAL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MGR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MGR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/mgr_pkg.sv
// ----------------------------------------------------------------------------
// Match geometry residual package
// Widths, register indexes and divider sizes shared by the residual block.
// ----------------------------------------------------------------------------
package mgr_pkg;

    localparam int COEF_W    = 32;
    localparam int PT_W      = 16;
    localparam int RES_W     = 20;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODEL_SELECT = 3'd0,
        CFG_COEF_0_1     = 3'd1,
        CFG_COEF_2_3     = 3'd2,
        CFG_COEF_4_5     = 3'd3,
        CFG_COEF_6_7     = 3'd4,
        CFG_COEF_8       = 3'd5
    } t_cfg_idx;

    localparam logic [COEF_W-1:0] COEF_ONE = 32'h0100_0000;

    localparam int DIV_NUM_W = 94;
    localparam int DIV_DEN_W = 62;
    localparam int DIV_Q_W   = 40;
    localparam int DIV_REM_W = DIV_DEN_W + DIV_Q_W;
    localparam int DIV_LAT   = DIV_Q_W + 1;

endpackage

// File: src/match_geometry_residual.sv
// ----------------------------------------------------------------------------
// Match geometry residual
// Takes one point correspondence per beat on the input channel (source and
// destination points, signed Q12.4) and returns one beat on the output
// channel: the residual in unsigned Q16.4, saturated, and a valid flag that
// is low when the denominator vanishes (residual then reads zero).
// Mode and the Q8.24 matrix are written through the register port; the user
// must write them only while no beat is in flight, which the block does not
// enforce; mode 0 gives the homography reprojection error, mode 1 the Sampson
// distance. A new beat is taken every cycle while the input is not stalled.
// The depth is mostly that of the two dividers and the 20-stage square root,
// one bit per stage.
// When the output beat is stalled the whole pipeline holds and the input
// stall is raised in the same cycle; nothing is dropped or repeated.
// Reset empties the pipeline, selects homography mode and loads the identity.
// ----------------------------------------------------------------------------
module match_geometry_residual import mgr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [PT_W-1:0]   i_src_x,
    input  logic signed [PT_W-1:0]   i_src_y,
    input  logic signed [PT_W-1:0]   i_dst_x,
    input  logic signed [PT_W-1:0]   i_dst_y,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [RES_W-1:0]         o_residual,
    output logic                     o_residual_valid
);

    localparam int PROD_W   = 48;
    localparam int SUM_W    = 49;
    localparam int MAG_W    = 48;
    localparam int SHIFT_W  = 5;
    localparam int NORM_W   = 30;
    localparam int SVAL_W   = 31;
    localparam int SQ_W     = 60;
    localparam int NP_W     = 47;
    localparam int NUM_W    = 48;
    localparam int NMAG_W   = 47;
    localparam int NH_W     = 23;
    localparam int NL_W     = 24;
    localparam int HGN_W    = 52;
    localparam int PROJ_W   = 31;
    localparam int PX_W     = 32;
    localparam int DX_W     = 33;
    localparam int AX_W     = 31;
    localparam int SS_W     = 62;
    localparam int SUMSQ_W  = 63;
    localparam int RAD_W    = 40;
    localparam int ROOT_W   = 20;
    localparam int FRONT    = 12;
    localparam int BACK     = 5;
    localparam int TOT      = FRONT + DIV_LAT + BACK + ROOT_W + 1;
    localparam int HG_FIRST = 4;
    localparam int HG_LAST  = FRONT - 2;
    localparam logic [PROJ_W-1:0] PROJ_LIM = 31'h4000_0000;
    localparam logic [RES_W-1:0]  RES_MAX  = '1;

    typedef struct packed {
        logic [HGN_W-1:0] num_x;
        logic [HGN_W-1:0] num_y;
        logic [MAG_W-1:0] den;
        logic             sgn_x;
        logic             sgn_y;
        logic             den_zero;
    } t_hg;

    typedef struct packed {
        logic signed [PT_W-1:0] x1;
        logic signed [PT_W-1:0] y1;
        logic                   sgn_x;
        logic                   sgn_y;
        logic                   bad;
    } t_side;

    typedef struct packed {
        logic [RAD_W-1:0] rad;
        logic             ovf;
        logic             bad;
    } t_back;

    // Configuration registers.
    logic              r_model_select;
    logic [CFG_W-1:0]  r_coef_0_1;
    logic [CFG_W-1:0]  r_coef_2_3;
    logic [CFG_W-1:0]  r_coef_4_5;
    logic [CFG_W-1:0]  r_coef_6_7;
    logic [COEF_W-1:0] r_coef_8;
    logic signed [COEF_W-1:0] m [0:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model_select <= 1'b0;
            r_coef_0_1     <= {{COEF_W{1'b0}}, COEF_ONE};
            r_coef_2_3     <= '0;
            r_coef_4_5     <= {{COEF_W{1'b0}}, COEF_ONE};
            r_coef_6_7     <= '0;
            r_coef_8       <= COEF_ONE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MODEL_SELECT: r_model_select <= i_cfg_data[0];
                CFG_COEF_0_1:     r_coef_0_1     <= i_cfg_data;
                CFG_COEF_2_3:     r_coef_2_3     <= i_cfg_data;
                CFG_COEF_4_5:     r_coef_4_5     <= i_cfg_data;
                CFG_COEF_6_7:     r_coef_6_7     <= i_cfg_data;
                CFG_COEF_8:       r_coef_8       <= i_cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    assign m[0] = r_coef_0_1[COEF_W-1:0];
    assign m[1] = r_coef_0_1[CFG_W-1:COEF_W];
    assign m[2] = r_coef_2_3[COEF_W-1:0];
    assign m[3] = r_coef_2_3[CFG_W-1:COEF_W];
    assign m[4] = r_coef_4_5[COEF_W-1:0];
    assign m[5] = r_coef_4_5[CFG_W-1:COEF_W];
    assign m[6] = r_coef_6_7[COEF_W-1:0];
    assign m[7] = r_coef_6_7[CFG_W-1:COEF_W];
    assign m[8] = r_coef_8;

    // Pipeline control.
    logic r_vld [0:TOT-1];
    logic en;

    assign en          = !(r_vld[TOT-1] && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_vld[TOT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TOT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int i = 1; i < TOT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // Front stages.
    logic signed [PT_W-1:0]   r_a_x0;
    logic signed [PT_W-1:0]   r_a_y0;
    logic signed [PT_W-1:0]   r_pt_x1 [0:HG_LAST];
    logic signed [PT_W-1:0]   r_pt_y1 [0:HG_LAST];
    logic signed [PROD_W-1:0] r_b_p [0:9];
    logic signed [SUM_W-1:0]  r_c_v [0:4];
    logic [MAG_W-1:0]         r_d_mag [0:4];
    logic                     r_d_sgn [0:4];
    logic [MAG_W-1:0]         r_e_mag [0:4];
    logic                     r_e_sgn [0:2];
    logic [SHIFT_W-1:0]       r_e_sh;
    t_hg                      r_hg [HG_FIRST:HG_LAST];
    logic [NORM_W-1:0]        r_f_sh [0:4];
    logic                     r_f_sgn [0:2];
    logic signed [SVAL_W-1:0] r_g_sv [0:2];
    logic [SQ_W-1:0]          r_g_sq [0:3];
    logic signed [NP_W-1:0]   r_h_n [0:1];
    logic signed [SVAL_W-1:0] r_h_sv2;
    logic [DIV_DEN_W-1:0]     r_h_d;
    logic signed [NUM_W-1:0]  r_i_n;
    logic [DIV_DEN_W-1:0]     r_i_d;
    logic                     r_i_dz;
    logic [NMAG_W-1:0]        r_j_nmag;
    logic [DIV_DEN_W-1:0]     r_j_d;
    logic                     r_j_dz;
    logic [2*NH_W-1:0]        r_k_hh;
    logic [NH_W+NL_W-1:0]     r_k_hl;
    logic [2*NL_W-1:0]        r_k_ll;
    logic [DIV_DEN_W-1:0]     r_k_d;
    logic                     r_k_dz;
    logic [DIV_NUM_W-1:0]     r_l_num_a;
    logic [DIV_DEN_W-1:0]     r_l_den_a;
    logic [DIV_NUM_W-1:0]     r_l_num_b;
    logic [DIV_DEN_W-1:0]     r_l_den_b;
    t_side                    r_l_side;

    logic [MAG_W-1:0]     n_or;
    logic [SHIFT_W-1:0]   n_sh;
    t_hg                  n_hg;
    logic [DIV_NUM_W-1:0] n_n2;

    always_comb begin
        n_or = r_d_mag[0] | r_d_mag[1] | r_d_mag[2] | r_d_mag[3] | r_d_mag[4];
        n_sh = '0;
        for (int b = NORM_W; b < MAG_W; b++) begin
            if (n_or[b]) begin
                n_sh = SHIFT_W'(b - (NORM_W - 1));
            end
        end
        n_hg.num_x    = {r_d_mag[0], 4'b0000};
        n_hg.num_y    = {r_d_mag[1], 4'b0000};
        n_hg.den      = r_d_mag[2];
        n_hg.sgn_x    = r_d_sgn[0] ^ r_d_sgn[2];
        n_hg.sgn_y    = r_d_sgn[1] ^ r_d_sgn[2];
        n_hg.den_zero = (r_d_mag[2] == '0);
        n_n2 = (DIV_NUM_W'(r_k_hh) << (2 * NL_W)) + (DIV_NUM_W'(r_k_hl) << (NL_W + 1))
             + DIV_NUM_W'(r_k_ll);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_x0     <= i_src_x;
            r_a_y0     <= i_src_y;
            r_pt_x1[0] <= i_dst_x;
            r_pt_y1[0] <= i_dst_y;
            for (int i = 1; i <= HG_LAST; i++) begin
                r_pt_x1[i] <= r_pt_x1[i-1];
                r_pt_y1[i] <= r_pt_y1[i-1];
            end

            r_b_p[0] <= m[0] * r_a_x0;
            r_b_p[1] <= m[1] * r_a_y0;
            r_b_p[2] <= m[3] * r_a_x0;
            r_b_p[3] <= m[4] * r_a_y0;
            r_b_p[4] <= m[6] * r_a_x0;
            r_b_p[5] <= m[7] * r_a_y0;
            r_b_p[6] <= m[0] * r_pt_x1[0];
            r_b_p[7] <= m[3] * r_pt_y1[0];
            r_b_p[8] <= m[1] * r_pt_x1[0];
            r_b_p[9] <= m[4] * r_pt_y1[0];

            r_c_v[0] <= SUM_W'(r_b_p[0]) + SUM_W'(r_b_p[1]) + (SUM_W'(m[2]) <<< 4);
            r_c_v[1] <= SUM_W'(r_b_p[2]) + SUM_W'(r_b_p[3]) + (SUM_W'(m[5]) <<< 4);
            r_c_v[2] <= SUM_W'(r_b_p[4]) + SUM_W'(r_b_p[5]) + (SUM_W'(m[8]) <<< 4);
            r_c_v[3] <= SUM_W'(r_b_p[6]) + SUM_W'(r_b_p[7]) + (SUM_W'(m[6]) <<< 4);
            r_c_v[4] <= SUM_W'(r_b_p[8]) + SUM_W'(r_b_p[9]) + (SUM_W'(m[7]) <<< 4);

            for (int i = 0; i < 5; i++) begin
                r_d_sgn[i] <= r_c_v[i][SUM_W-1];
                r_d_mag[i] <= r_c_v[i][SUM_W-1] ? MAG_W'(-r_c_v[i]) : MAG_W'(r_c_v[i]);
                r_e_mag[i] <= r_d_mag[i];
                r_f_sh[i]  <= NORM_W'(r_e_mag[i] >> r_e_sh);
            end
            for (int i = 0; i < 3; i++) begin
                r_e_sgn[i] <= r_d_sgn[i];
                r_f_sgn[i] <= r_e_sgn[i];
                r_g_sv[i]  <= r_f_sgn[i] ? -SVAL_W'(r_f_sh[i]) : SVAL_W'(r_f_sh[i]);
            end
            r_e_sh <= n_sh;

            r_hg[HG_FIRST] <= n_hg;
            for (int i = HG_FIRST + 1; i <= HG_LAST; i++) begin
                r_hg[i] <= r_hg[i-1];
            end

            r_g_sq[0] <= r_f_sh[0] * r_f_sh[0];
            r_g_sq[1] <= r_f_sh[1] * r_f_sh[1];
            r_g_sq[2] <= r_f_sh[3] * r_f_sh[3];
            r_g_sq[3] <= r_f_sh[4] * r_f_sh[4];

            r_h_n[0] <= r_pt_x1[6] * r_g_sv[0];
            r_h_n[1] <= r_pt_y1[6] * r_g_sv[1];
            r_h_sv2  <= r_g_sv[2];
            r_h_d    <= DIV_DEN_W'(r_g_sq[0]) + DIV_DEN_W'(r_g_sq[1])
                      + DIV_DEN_W'(r_g_sq[2]) + DIV_DEN_W'(r_g_sq[3]);

            r_i_n  <= NUM_W'(r_h_n[0]) + NUM_W'(r_h_n[1]) + (NUM_W'(r_h_sv2) <<< 4);
            r_i_d  <= r_h_d;
            r_i_dz <= (r_h_d == '0);

            r_j_nmag <= r_i_n[NUM_W-1] ? NMAG_W'(-r_i_n) : NMAG_W'(r_i_n);
            r_j_d    <= r_i_d;
            r_j_dz   <= r_i_dz;

            r_k_hh <= r_j_nmag[NMAG_W-1:NL_W] * r_j_nmag[NMAG_W-1:NL_W];
            r_k_hl <= r_j_nmag[NMAG_W-1:NL_W] * r_j_nmag[NL_W-1:0];
            r_k_ll <= r_j_nmag[NL_W-1:0] * r_j_nmag[NL_W-1:0];
            r_k_d  <= r_j_d;
            r_k_dz <= r_j_dz;

            r_l_num_a      <= r_model_select ? n_n2 : DIV_NUM_W'(r_hg[HG_LAST].num_x);
            r_l_den_a      <= r_model_select ? r_k_d : DIV_DEN_W'(r_hg[HG_LAST].den);
            r_l_num_b      <= DIV_NUM_W'(r_hg[HG_LAST].num_y);
            r_l_den_b      <= DIV_DEN_W'(r_hg[HG_LAST].den);
            r_l_side.x1    <= r_pt_x1[HG_LAST];
            r_l_side.y1    <= r_pt_y1[HG_LAST];
            r_l_side.sgn_x <= r_hg[HG_LAST].sgn_x;
            r_l_side.sgn_y <= r_hg[HG_LAST].sgn_y;
            r_l_side.bad   <= r_model_select ? r_k_dz : r_hg[HG_LAST].den_zero;
        end
    end

    // Dividers.
    logic [DIV_Q_W-1:0] quo_a;
    logic [DIV_Q_W-1:0] quo_b;
    logic               ovf_a;
    logic               ovf_b;
    t_side              r_dv_side [0:DIV_LAT-1];

    mgr_div u_div_a (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_l_num_a),
        .i_den (r_l_den_a),
        .o_quo (quo_a),
        .o_ovf (ovf_a)
    );

    mgr_div u_div_b (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_l_num_b),
        .i_den (r_l_den_b),
        .o_quo (quo_b),
        .o_ovf (ovf_b)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_side[0] <= r_l_side;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_dv_side[i] <= r_dv_side[i-1];
            end
        end
    end

    // Back stages.
    function automatic logic signed [PX_W-1:0] f_proj(
        input logic [DIV_Q_W-1:0] quo,
        input logic               ovf,
        input logic               sgn
    );
        logic [PROJ_W-1:0] mag_q;
        mag_q = (ovf || (quo > DIV_Q_W'(PROJ_LIM))) ? PROJ_LIM : quo[PROJ_W-1:0];
        return sgn ? -PX_W'(mag_q) : PX_W'(mag_q);
    endfunction

    logic signed [PX_W-1:0] r_m_px;
    logic signed [PX_W-1:0] r_m_py;
    logic signed [PT_W-1:0] r_m_x1;
    logic signed [PT_W-1:0] r_m_y1;
    t_back                  r_m_bk;
    logic signed [DX_W-1:0] r_n_dx;
    logic signed [DX_W-1:0] r_n_dy;
    t_back                  r_n_bk;
    logic [AX_W-1:0]        r_o_ax;
    logic [AX_W-1:0]        r_o_ay;
    t_back                  r_o_bk;
    logic [SS_W-1:0]        r_p_sx;
    logic [SS_W-1:0]        r_p_sy;
    t_back                  r_p_bk;
    logic [RAD_W-1:0]       r_q_rad;
    logic                   r_q_sat;
    logic                   r_q_bad;
    logic [SUMSQ_W-1:0]     n_sumsq;

    assign n_sumsq = SUMSQ_W'(r_p_sx) + SUMSQ_W'(r_p_sy);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_px     <= f_proj(quo_a, ovf_a, r_dv_side[DIV_LAT-1].sgn_x);
            r_m_py     <= f_proj(quo_b, ovf_b, r_dv_side[DIV_LAT-1].sgn_y);
            r_m_x1     <= r_dv_side[DIV_LAT-1].x1;
            r_m_y1     <= r_dv_side[DIV_LAT-1].y1;
            r_m_bk.rad <= quo_a;
            r_m_bk.ovf <= ovf_a;
            r_m_bk.bad <= r_dv_side[DIV_LAT-1].bad;

            r_n_dx <= DX_W'(r_m_px) - DX_W'(r_m_x1);
            r_n_dy <= DX_W'(r_m_py) - DX_W'(r_m_y1);
            r_n_bk <= r_m_bk;

            r_o_ax <= r_n_dx[DX_W-1] ? AX_W'(-r_n_dx) : AX_W'(r_n_dx);
            r_o_ay <= r_n_dy[DX_W-1] ? AX_W'(-r_n_dy) : AX_W'(r_n_dy);
            r_o_bk <= r_n_bk;

            r_p_sx <= r_o_ax * r_o_ax;
            r_p_sy <= r_o_ay * r_o_ay;
            r_p_bk <= r_o_bk;

            r_q_rad <= r_model_select ? r_p_bk.rad : n_sumsq[RAD_W-1:0];
            r_q_sat <= r_model_select ? r_p_bk.ovf : (n_sumsq[SUMSQ_W-1:RAD_W] != '0);
            r_q_bad <= r_p_bk.bad;
        end
    end

    // Square root, one root bit per stage.
    logic [RAD_W-1:0]  r_sr_rem  [0:ROOT_W-2];
    logic [ROOT_W-1:0] r_sr_root [0:ROOT_W-1];
    logic              r_sr_sat  [0:ROOT_W-1];
    logic              r_sr_bad  [0:ROOT_W-1];
    logic [RAD_W-1:0]  sr_in_rem  [0:ROOT_W-1];
    logic [ROOT_W-1:0] sr_in_root [0:ROOT_W-1];
    logic              sr_in_sat  [0:ROOT_W-1];
    logic              sr_in_bad  [0:ROOT_W-1];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        localparam int B = ROOT_W - 1 - j;
        logic [RAD_W:0] n_trial;
        logic           n_fits;

        if (j == 0) begin : g_head
            assign sr_in_rem[j]  = r_q_rad;
            assign sr_in_root[j] = '0;
            assign sr_in_sat[j]  = r_q_sat;
            assign sr_in_bad[j]  = r_q_bad;
        end else begin : g_link
            assign sr_in_rem[j]  = r_sr_rem[j-1];
            assign sr_in_root[j] = r_sr_root[j-1];
            assign sr_in_sat[j]  = r_sr_sat[j-1];
            assign sr_in_bad[j]  = r_sr_bad[j-1];
        end

        assign n_trial = ((RAD_W+1)'(sr_in_root[j]) << (B + 1))
                       | ((RAD_W+1)'(1) << (2 * B));
        assign n_fits  = ({1'b0, sr_in_rem[j]} >= n_trial);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sr_root[j] <= sr_in_root[j] | ({{(ROOT_W-1){1'b0}}, n_fits} << B);
                r_sr_sat[j]  <= sr_in_sat[j];
                r_sr_bad[j]  <= sr_in_bad[j];
            end
        end

        if (j < ROOT_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_sr_rem[j] <= n_fits ? (sr_in_rem[j] - n_trial[RAD_W-1:0])
                                          : sr_in_rem[j];
                end
            end
        end
    end

    // Output register.
    logic [RES_W-1:0] r_out_res;
    logic             r_out_ok;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_res <= r_sr_bad[ROOT_W-1] ? '0 :
                         r_sr_sat[ROOT_W-1] ? RES_MAX : r_sr_root[ROOT_W-1];
            r_out_ok  <= !r_sr_bad[ROOT_W-1];
        end
    end

    assign o_residual       = r_out_res;
    assign o_residual_valid = r_out_ok;

endmodule

// File: src/mgr_div.sv
// ----------------------------------------------------------------------------
// Match geometry residual divider
// Pipelined restoring divider, one quotient bit per stage, with a flag for
// quotients that do not fit the quotient width.
// ----------------------------------------------------------------------------
module mgr_div import mgr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic [DIV_Q_W-1:0]   o_quo,
    output logic                 o_ovf
);

    logic [DIV_REM_W-1:0] r_rem [0:DIV_Q_W-1];
    logic [DIV_DEN_W-1:0] r_den [0:DIV_Q_W-1];
    logic [DIV_Q_W-1:0]   r_quo [0:DIV_Q_W];
    logic                 r_ovf [0:DIV_Q_W];
    logic [DIV_REM_W-1:0] n_den_top;
    logic [DIV_REM_W-1:0] n_num_ext;

    assign n_den_top = {i_den, {DIV_Q_W{1'b0}}};
    assign n_num_ext = {{(DIV_REM_W-DIV_NUM_W){1'b0}}, i_num};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_num_ext;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_ovf[0] <= (n_num_ext >= n_den_top);
        end
    end

    for (genvar k = 0; k < DIV_Q_W; k++) begin : g_step
        localparam int SH = DIV_Q_W - 1 - k;
        logic [DIV_REM_W-1:0] n_trial;
        logic                 n_fits;

        assign n_trial = {{(DIV_REM_W-DIV_DEN_W){1'b0}}, r_den[k]} << SH;
        assign n_fits  = (r_rem[k] >= n_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k+1] <= r_quo[k] | ({{(DIV_Q_W-1){1'b0}}, n_fits} << SH);
                r_ovf[k+1] <= r_ovf[k];
            end
        end

        if (k < DIV_Q_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= n_fits ? (r_rem[k] - n_trial) : r_rem[k];
                    r_den[k+1] <= r_den[k];
                end
            end
        end
    end

    assign o_quo = r_quo[DIV_Q_W];
    assign o_ovf = r_ovf[DIV_Q_W];

endmodule

// File: src/mgr_checker.sv
// ----------------------------------------------------------------------------
// Match geometry residual checker
// Port-level assertions on the residual block, attached by a bind.
// ----------------------------------------------------------------------------
`include "match_geometry_residual_defines.svh"

module mgr_checker import mgr_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [RES_W-1:0] o_residual,
    input logic             o_residual_valid
);

    `MGR_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_residual) && $stable(o_residual_valid),
        "stalled output beat changed")
    `MGR_ASSERT_SAME(a_bad_zero, o_out_valid && !o_residual_valid, o_residual == '0,
        "invalid residual is not zero")
    `MGR_ASSERT_SAME(a_stall_src, o_in_stall, o_out_valid && i_out_stall,
        "input stalled without an output stall")

endmodule

bind match_geometry_residual mgr_checker u_mgr_checker (.*);
